/* rtl/bounded_id_set_assert.svh */
// Assertion macros for the checker file of the id set.
`ifndef BOUNDED_ID_SET_ASSERT_SVH
`define BOUNDED_ID_SET_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define BIS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bounded_id_set: same-cycle check failed");

// Next-cycle implication, disabled while reset is held.
`define BIS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bounded_id_set: next-cycle check failed");

`endif

/* rtl/bis_pkg.sv */
// Types and codes shared by the id set and its checker.
package bis_pkg;

  typedef enum logic [1:0] {
    FUNC_ADD  = 2'd0,
    FUNC_DEL  = 2'd1,
    FUNC_CHK  = 2'd2,
    FUNC_READ = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_ID    = 3'd1,
    ST_FULL      = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_RANGE     = 3'd4
  } status_t;

  localparam int unsigned IDENT_W = 32;
  localparam int unsigned SLOT_W  = 4;
  localparam int unsigned OCC_W   = 5;

endpackage

/* rtl/bis_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
module bis_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                         clk,
  input  logic                                         wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                             wr_data,
  input  logic                                         rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                             rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/bounded_id_set.sv */
// Fixed-capacity id set held as a dense array with a count, with swap-remove delete.
//
// Each request adds an id at the end of the array, deletes an id (the last
// entry moves into the freed position), checks membership, or reads the entry
// at a position; every result carries a status and the count after the
// operation. The ids zero and all-ones are refused. One request is handled at
// a time, and ready is low while it runs. An add, a refused request and a
// read out of range go from acceptance straight to the done state, a read in
// range passes through the read state first. A check compares one stored
// entry per cycle through the single read port of the entry memory in the
// scan state, and a delete first fetches the last entry in the last state.
// The result waits in the done state until the output register is free or
// being emptied. The next request is accepted as soon as the result has
// moved into the output register, even if the consumer has not taken it yet.
// The entry memory needs no clearing after reset, since only positions below
// the count are ever read.
module bounded_id_set
  import bis_pkg::*;
#(
  parameter int unsigned CAPACITY = 16,
  parameter int unsigned ID_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_func,
  input  logic [IDENT_W-1:0] in_ident,
  input  logic [SLOT_W-1:0]  in_slot,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_status,
  output logic               out_found,
  output logic [IDENT_W-1:0] out_read_ident,
  output logic [OCC_W-1:0]   out_occupancy
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  // The no-id value is all ones at the stored width; it is reported through
  // the fixed-width output port, so it is resized the same way as entries.
  localparam logic [ID_WIDTH-1:0] NO_ID     = '1;
  localparam logic [63:0]         NO_ID_EXT = 64'(NO_ID);
  localparam logic [IDENT_W-1:0]  NO_ID_OUT = NO_ID_EXT[IDENT_W-1:0];

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_LAST,
    S_SCAN,
    S_DONE
  } state_t;

  state_t              state_r, state_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  func_t               func_r, func_nxt;
  logic [ID_WIDTH-1:0] ident_r, ident_nxt;
  logic [ID_WIDTH-1:0] last_r, last_nxt;
  logic [AW-1:0]       pos_r, pos_nxt;
  status_t             res_status_r, res_status_nxt;
  logic                res_found_r, res_found_nxt;
  logic [IDENT_W-1:0]  res_read_r, res_read_nxt;
  logic                out_valid_r, out_valid_nxt;
  status_t             out_status_r, out_status_nxt;
  logic                out_found_r, out_found_nxt;
  logic [IDENT_W-1:0]  out_read_r, out_read_nxt;
  logic [OCC_W-1:0]    out_occ_r, out_occ_nxt;

  // Entry memory ports.
  logic                mem_wr_en;
  logic [AW-1:0]       mem_wr_addr;
  logic [ID_WIDTH-1:0] mem_wr_data;
  logic                mem_rd_en;
  logic [AW-1:0]       mem_rd_addr;
  logic [ID_WIDTH-1:0] mem_rd_data;

  logic                in_fire;
  func_t               in_func_w;
  logic [63:0]         in_ident_ext;
  logic [ID_WIDTH-1:0] in_ident_w;
  logic                in_id_ok;
  logic [8:0]          slot9;
  logic [8:0]          cnt9;
  logic [8:0]          last9;
  logic [63:0]         rd_ext;
  logic                hit;
  logic                at_last;

  bis_ram #(
    .WIDTH(ID_WIDTH),
    .DEPTH(CAPACITY)
  ) u_entries (
    .clk    (clk),
    .wr_en  (mem_wr_en),
    .wr_addr(mem_wr_addr),
    .wr_data(mem_wr_data),
    .rd_en  (mem_rd_en),
    .rd_addr(mem_rd_addr),
    .rd_data(mem_rd_data)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign in_func_w = func_t'(in_func);

  // Incoming ids are taken modulo two to the stored width.
  assign in_ident_ext = 64'(in_ident);
  assign in_ident_w   = in_ident_ext[ID_WIDTH-1:0];
  assign in_id_ok     = (in_ident_w != '0) && (in_ident_w != NO_ID);

  assign slot9 = 9'(in_slot);
  assign cnt9  = 9'(count_r);
  assign last9 = cnt9 - 9'd1;

  assign rd_ext  = 64'(mem_rd_data);
  assign hit     = (mem_rd_data == ident_r);
  assign at_last = (9'(pos_r) == last9);

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    func_nxt       = func_r;
    ident_nxt      = ident_r;
    last_nxt       = last_r;
    pos_nxt        = pos_r;
    res_status_nxt = res_status_r;
    res_found_nxt  = res_found_r;
    res_read_nxt   = res_read_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_found_nxt  = out_found_r;
    out_read_nxt   = out_read_r;
    out_occ_nxt    = out_occ_r;
    mem_wr_en      = 1'b0;
    mem_wr_addr    = pos_r;
    mem_wr_data    = last_r;
    mem_rd_en      = 1'b0;
    mem_rd_addr    = '0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          func_nxt       = in_func_w;
          ident_nxt      = in_ident_w;
          res_status_nxt = ST_OK;
          res_found_nxt  = 1'b0;
          res_read_nxt   = NO_ID_OUT;
          state_nxt      = S_DONE;
          unique case (in_func_w)
            FUNC_ADD: begin
              if (!in_id_ok) begin
                res_status_nxt = ST_BAD_ID;
              end else if (count_r == CW'(CAPACITY)) begin
                res_status_nxt = ST_FULL;
              end else begin
                // Append at the current end of the array.
                mem_wr_en   = 1'b1;
                mem_wr_addr = cnt9[AW-1:0];
                mem_wr_data = in_ident_w;
                count_nxt   = count_r + CW'(1);
              end
            end
            FUNC_DEL, FUNC_CHK: begin
              if (!in_id_ok) begin
                res_status_nxt = ST_BAD_ID;
              end else if (count_r == '0) begin
                res_status_nxt = (in_func_w == FUNC_DEL) ? ST_NOT_FOUND : ST_OK;
              end else if (in_func_w == FUNC_DEL) begin
                // Fetch the last entry first; it fills the hole of a delete.
                mem_rd_en   = 1'b1;
                mem_rd_addr = last9[AW-1:0];
                state_nxt   = S_LAST;
              end else begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = '0;
                pos_nxt     = '0;
                state_nxt   = S_SCAN;
              end
            end
            FUNC_READ: begin
              if ((slot9 >= cnt9) || (slot9 >= 9'(CAPACITY))) begin
                res_status_nxt = ST_RANGE;
              end else begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = slot9[AW-1:0];
                state_nxt   = S_READ;
              end
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_READ: begin
        res_read_nxt = rd_ext[IDENT_W-1:0];
        state_nxt    = S_DONE;
      end
      S_LAST: begin
        last_nxt    = mem_rd_data;
        mem_rd_en   = 1'b1;
        mem_rd_addr = '0;
        pos_nxt     = '0;
        state_nxt   = S_SCAN;
      end
      S_SCAN: begin
        // The read data holds the entry at pos_r; the lowest match wins.
        if (hit) begin
          if (func_r == FUNC_DEL) begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = pos_r;
            mem_wr_data = last_r;
            count_nxt   = count_r - CW'(1);
          end else begin
            res_found_nxt = 1'b1;
          end
          state_nxt = S_DONE;
        end else if (at_last) begin
          res_status_nxt = (func_r == FUNC_DEL) ? ST_NOT_FOUND : ST_OK;
          state_nxt      = S_DONE;
        end else begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = pos_r + AW'(1);
          pos_nxt     = pos_r + AW'(1);
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_found_nxt  = res_found_r;
          out_read_nxt   = res_read_r;
          out_occ_nxt    = cnt9[OCC_W-1:0];
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    func_r       <= func_nxt;
    ident_r      <= ident_nxt;
    last_r       <= last_nxt;
    pos_r        <= pos_nxt;
    res_status_r <= res_status_nxt;
    res_found_r  <= res_found_nxt;
    res_read_r   <= res_read_nxt;
    out_status_r <= out_status_nxt;
    out_found_r  <= out_found_nxt;
    out_read_r   <= out_read_nxt;
    out_occ_r    <= out_occ_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_found      = out_found_r;
  assign out_read_ident = out_read_r;
  assign out_occupancy  = out_occ_r;

endmodule

/* rtl/bis_checker.sv */
// Port-level checker for the id set, with its bind to the top level.
`include "bounded_id_set_assert.svh"

module bis_checker
  import bis_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic [2:0]         out_status,
  input logic               out_found,
  input logic [IDENT_W-1:0] out_read_ident,
  input logic [OCC_W-1:0]   out_occupancy
);

  `BIS_ASSERT_IMPLY(a_found_only_ok, clk, rst_n, out_valid && out_found, out_status == ST_OK)
  `BIS_ASSERT_IMPLY(a_found_nonempty, clk, rst_n, out_valid && out_found, (CAPACITY >= 32) || (out_occupancy != '0))
  `BIS_ASSERT_IMPLY(a_full_count, clk, rst_n, out_valid && (out_status == ST_FULL), out_occupancy == OCC_W'(CAPACITY))
  `BIS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_status) && $stable(out_found) && $stable(out_read_ident) && $stable(out_occupancy))

endmodule

bind bounded_id_set bis_checker #(
  .CAPACITY(CAPACITY)
) u_bis_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_status    (out_status),
  .out_found     (out_found),
  .out_read_ident(out_read_ident),
  .out_occupancy (out_occupancy)
);

/* verif/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the bounded id set: directed and random requests, scored live.
module testbench;
  import bis_pkg::*;

  localparam int unsigned SET_CAPACITY     = 16;
  localparam int unsigned CLK_PERIOD       = 10;
  localparam int unsigned RESET_CYCLES     = 11;
  localparam int unsigned RANDOM_REQUESTS  = 820;
  // The last stretch of random requests runs with both sides always willing.
  localparam int unsigned CALM_REQUESTS    = 100;
  localparam int unsigned PHASE_LENGTH     = 60;
  localparam int unsigned LONG_HOLD_START  = 300;
  localparam int unsigned DRAIN_PAUSE_AT   = 550;
  localparam int unsigned LONG_HOLD_CYCLES = 400;
  // Slowest request is a delete on a full set; the longest quiet stretch is the long
  // consumer hold, so reaching the stall limit without any handshake means a hang.
  localparam int unsigned STALL_LIMIT      = 3000;
  localparam int unsigned TAIL_CYCLES      = 25;
  localparam int unsigned POOL_SIZE        = 24;
  localparam int unsigned REPORT_LIMIT     = 10;
  localparam logic [IDENT_W-1:0] NO_IDENT  = '1;

  // One expected response, field for field as the block drives it.
  typedef struct {
    status_t            status;
    logic               found;
    logic [IDENT_W-1:0] read_ident;
    logic [OCC_W-1:0]   occupancy;
  } outcome_t;

  // Scoreboard: keeps its own copy of the set, predicts the response of every accepted
  // request and compares each response from the block against the oldest prediction.
  class id_set_scoreboard;
    logic [IDENT_W-1:0] held [SET_CAPACITY];
    int unsigned        occupied;
    outcome_t           awaited [$];
    int unsigned        mismatches;

    function new();
      occupied   = 0;
      mismatches = 0;
    endfunction

    function int unsigned pending();
      return awaited.size();
    endfunction

    function int position_of(logic [IDENT_W-1:0] ident);
      for (int i = 0; i < occupied; i++) begin
        if (held[i] == ident) return i;
      end
      return -1;
    endfunction

    function void note_request(func_t func, logic [IDENT_W-1:0] ident,
                               logic [SLOT_W-1:0] slot);
      outcome_t o;
      bit       usable;
      int       pos;
      o.status     = ST_OK;
      o.found      = 1'b0;
      o.read_ident = NO_IDENT;
      usable       = (ident != '0) && (ident != NO_IDENT);
      case (func)
        FUNC_ADD: begin
          if (!usable) begin
            o.status = ST_BAD_ID;
          end else if (occupied >= SET_CAPACITY) begin
            o.status = ST_FULL;
          end else begin
            held[occupied] = ident;
            occupied++;
          end
        end
        FUNC_DEL: begin
          if (!usable) begin
            o.status = ST_BAD_ID;
          end else begin
            pos = position_of(ident);
            if (pos < 0) begin
              o.status = ST_NOT_FOUND;
            end else begin
              // The last entry fills the hole left by the lowest match.
              occupied--;
              held[pos] = held[occupied];
            end
          end
        end
        FUNC_CHK: begin
          if (!usable) o.status = ST_BAD_ID;
          else o.found = (position_of(ident) >= 0);
        end
        default: begin
          if (slot >= occupied) o.status = ST_RANGE;
          else o.read_ident = held[slot];
        end
      endcase
      o.occupancy = OCC_W'(occupied);
      awaited.push_back(o);
    endfunction

    function void compare_field(string field, logic [IDENT_W-1:0] want,
                                logic [IDENT_W-1:0] got);
      if (want !== got) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("mismatch in %s: expected %0h, got %0h", field, want, got);
      end
    endfunction

    function void check_result(logic [2:0] status, logic found,
                               logic [IDENT_W-1:0] read_ident, logic [OCC_W-1:0] occupancy);
      outcome_t o;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("response with no request outstanding: status %0d occupancy %0d",
                   status, occupancy);
        return;
      end
      o = awaited.pop_front();
      compare_field("status", IDENT_W'(o.status), IDENT_W'(status));
      compare_field("found", IDENT_W'(o.found), IDENT_W'(found));
      compare_field("read_ident", o.read_ident, read_ident);
      compare_field("occupancy", IDENT_W'(o.occupancy), IDENT_W'(occupancy));
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [1:0]         in_func;
  logic [IDENT_W-1:0] in_ident;
  logic [SLOT_W-1:0]  in_slot;
  logic               out_valid;
  logic               out_ready;
  logic [2:0]         out_status;
  logic               out_found;
  logic [IDENT_W-1:0] out_read_ident;
  logic [OCC_W-1:0]   out_occupancy;

  id_set_scoreboard   sb = new();

  // Random idling on both sides is switched off for the final stretch of the run.
  bit                 gaps_on = 1'b1;
  // Raised by the stimulus to make the consumer hold off for a long stretch.
  bit                 long_hold_req = 1'b0;
  int unsigned        quiet_cycles = 0;

  // Ids that the random requests mostly draw from, so deletes and checks hit stored ids.
  logic [IDENT_W-1:0] id_pool [POOL_SIZE];
  // Corner ids used while filling the set in the directed part; five appears twice.
  logic [IDENT_W-1:0] corner_ids [6] = '{32'h0000_0001, 32'hffff_fffe, 32'h8000_0000,
                                         32'h7fff_ffff, 32'h0000_0005, 32'h0000_0005};

  bounded_id_set dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_func        (in_func),
    .in_ident       (in_ident),
    .in_slot        (in_slot),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_found      (out_found),
    .out_read_ident (out_read_ident),
    .out_occupancy  (out_occupancy)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Offers one request, optionally after a random idle burst, and returns at the edge where
  // it is accepted. Valid stays high on return so back-to-back requests need no bubble.
  task automatic send_request(input func_t func, input logic [IDENT_W-1:0] ident,
                              input logic [SLOT_W-1:0] slot);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func  <= func;
    in_ident <= ident;
    in_slot  <= slot;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stops offering and waits until every predicted response has come back.
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // Mostly ids from the pool; the rest are arbitrary words and the two refused ids.
  function automatic logic [IDENT_W-1:0] pick_ident();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 78) return id_pool[$urandom_range(0, POOL_SIZE - 1)];
    if (roll < 90) return IDENT_W'($urandom());
    if (roll < 95) return '0;
    return NO_IDENT;
  endfunction

  // Fill phases lean on adds so the set reaches full; drain phases lean on deletes so it
  // empties again. Reads mostly target occupied positions, sometimes any position.
  task automatic send_random(input bit filling);
    int unsigned       roll;
    int unsigned       held_now;
    func_t             func;
    logic [SLOT_W-1:0] slot;
    roll     = $urandom_range(0, 99);
    held_now = sb.occupied;
    if (filling)
      func = (roll < 55) ? FUNC_ADD : (roll < 65) ? FUNC_DEL : (roll < 80) ? FUNC_CHK : FUNC_READ;
    else
      func = (roll < 15) ? FUNC_ADD : (roll < 65) ? FUNC_DEL : (roll < 80) ? FUNC_CHK : FUNC_READ;
    if (func == FUNC_READ && held_now > 0 && $urandom_range(0, 3) != 0)
      slot = SLOT_W'($urandom_range(0, held_now - 1));
    else
      slot = SLOT_W'($urandom_range(0, 15));
    send_request(func, pick_ident(), slot);
  endtask

  // Consumer side: random ready and stall bursts, plus the long hold on request. Each pass
  // makes one assignment to out_ready and then waits on the clock before the next pass.
  initial begin : consumer
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
      end else if (gaps_on && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  // Monitor: both handshakes are sampled at the rising edge, before the block's registers
  // change. The same block keeps the watchdog that ends a hung run.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready)
        sb.note_request(func_t'(in_func), in_ident, in_slot);
      if (out_valid && out_ready)
        sb.check_result(out_status, out_found, out_read_ident, out_occupancy);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("timeout: no handshake for %0d cycles", quiet_cycles);
          $display("FAIL");
          $finish;
        end
      end
    end
  end

  initial begin : stimulus
    logic [IDENT_W-1:0] candidate;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_func  <= FUNC_ADD;
    in_ident <= '0;
    in_slot  <= '0;
    for (int i = 0; i < POOL_SIZE; i++) begin
      do candidate = IDENT_W'($urandom()); while (candidate == '0 || candidate == NO_IDENT);
      id_pool[i] = candidate;
    end
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. Refused ids and an empty set come first.
    send_request(FUNC_READ, '0, '0);
    send_request(FUNC_ADD, '0, '0);
    send_request(FUNC_ADD, NO_IDENT, '0);
    send_request(FUNC_DEL, '0, 4'hf);
    send_request(FUNC_CHK, NO_IDENT, '0);
    send_request(FUNC_DEL, 32'h0000_0005, '0);
    // Fill the set to capacity, with corner ids and one duplicate among them.
    for (int i = 0; i < SET_CAPACITY; i++)
      send_request(FUNC_ADD, (i < 6) ? corner_ids[i] : IDENT_W'(32'h100 + i), SLOT_W'(i));
    // An add to a full set, then a read of the highest position and a check of a stored id.
    send_request(FUNC_ADD, 32'h0000_0042, '0);
    send_request(FUNC_READ, NO_IDENT, 4'hf);
    send_request(FUNC_CHK, 32'h7fff_ffff, '0);
    // Deleting the duplicated id removes only its lower copy, so it is still present after.
    send_request(FUNC_DEL, 32'h0000_0005, '0);
    send_request(FUNC_CHK, 32'h0000_0005, '0);
    send_request(FUNC_READ, '0, 4'h4);
    send_request(FUNC_DEL, 32'h0000_0042, '0);

    // The producer pauses here until every response is back.
    hold_until_drained();

    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n == RANDOM_REQUESTS - CALM_REQUESTS) gaps_on = 1'b0;
      // The consumer holds off while requests keep coming, so the block backs up.
      if (n == LONG_HOLD_START) long_hold_req = 1'b1;
      if (n == DRAIN_PAUSE_AT) hold_until_drained();
      send_random(((n / PHASE_LENGTH) % 2) == 0);
    end

    hold_until_drained();
    // A tail of idle clocks catches any response the block sends that nobody asked for.
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches, %0d responses missing", sb.mismatches, sb.pending());
      $display("FAIL");
    end
    $finish;
  end

endmodule
